### design/afs_pkg.sv
// ----------------------------------------------------------------------------
// afs_pkg
// Types and constants for the audio frame sequencer.
// ----------------------------------------------------------------------------
package afs_pkg;

	localparam int ACTION_W = 2;
	localparam int VALUE_W  = 8;
	localparam int COUNT_W  = 16;

	localparam logic [ACTION_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_STATUS = 2'd2;

	localparam logic [COUNT_W-1:0] SEQ_Q1    = 16'd7459;
	localparam logic [COUNT_W-1:0] SEQ_Q2    = 16'd14915;
	localparam logic [COUNT_W-1:0] SEQ_Q3    = 16'd22373;
	localparam logic [COUNT_W-1:0] SEQ_IRQ_A = 16'd29830;
	localparam logic [COUNT_W-1:0] SEQ_IRQ_B = 16'd29831;
	localparam logic [COUNT_W-1:0] SEQ_IRQ_C = 16'd29832;
	localparam logic [COUNT_W:0]   SEQ_WRAP4 = 17'd37289;
	localparam logic [COUNT_W-1:0] SEQ_LAST5 = 16'd37283;
	localparam logic [COUNT_W:0]   SEQ_WRAP5 = 17'd44741;

	localparam int MODE_FIVE_BIT   = 7;
	localparam int IRQ_INHIBIT_BIT = 6;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VALUE_W-1:0]  value;
	} item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] cycle_position;
		logic [VALUE_W-1:0] frame_register_value;
		logic               write_pending;
		logic               irq_flag;
	} seq_state_t;

	typedef struct packed {
		logic               quarter_frame;
		logic               half_frame;
		logic               half_rate_strobe;
		logic               irq_request;
		logic               irq_seen;
		logic [VALUE_W-1:0] frame_register_read;
	} result_t;

endpackage

### design/afs_in_if.sv
// ----------------------------------------------------------------------------
// afs_in_if
// Input channel: one action and its data byte per transfer.
// ----------------------------------------------------------------------------
interface afs_in_if;
	import afs_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [VALUE_W-1:0]  value;

	modport source (output valid, output action, output value, input ready);
	modport sink   (input valid, input action, input value, output ready);
endinterface

### design/afs_out_if.sv
// ----------------------------------------------------------------------------
// afs_out_if
// Result channel: frame pulses, strobe, IRQ state and register readback.
// ----------------------------------------------------------------------------
interface afs_out_if;
	import afs_pkg::*;

	logic               valid;
	logic               ready;
	logic               quarter_frame;
	logic               half_frame;
	logic               half_rate_strobe;
	logic               irq_request;
	logic               irq_seen;
	logic [VALUE_W-1:0] frame_register_read;

	modport source (
		output valid, output quarter_frame, output half_frame, output half_rate_strobe,
		output irq_request, output irq_seen, output frame_register_read, input ready
	);
	modport sink (
		input valid, input quarter_frame, input half_frame, input half_rate_strobe,
		input irq_request, input irq_seen, input frame_register_read, output ready
	);
endinterface

### design/afs_step.sv
// ----------------------------------------------------------------------------
// afs_step
// Next-state and result logic for one item against the sequencer state.
// ----------------------------------------------------------------------------
module afs_step (
	input  afs_pkg::item_t      item,
	input  afs_pkg::seq_state_t cur,
	output afs_pkg::seq_state_t nxt,
	output afs_pkg::result_t    res
);
	import afs_pkg::*;

	always_comb begin
		logic [COUNT_W-1:0] c;
		logic [COUNT_W:0]   c_inc;
		logic               five;
		logic               inhibit;
		logic               quarter;
		logic               half;
		logic               strobe;
		logic               seen;

		nxt     = cur;
		c       = cur.cycle_position;
		c_inc   = '0;
		five    = cur.frame_register_value[MODE_FIVE_BIT];
		inhibit = cur.frame_register_value[IRQ_INHIBIT_BIT];
		quarter = 1'b0;
		half    = 1'b0;
		strobe  = 1'b0;
		seen    = 1'b0;

		unique case (item.action)
			ACT_TICK: begin
				// pending write restarts the sequence on an even count
				if (cur.write_pending && !c[0]) begin
					nxt.write_pending = 1'b0;
					c = '0;
					if (five) begin
						quarter = 1'b1;
						half    = 1'b1;
					end
					if (inhibit) begin
						nxt.irq_flag = 1'b0;
					end
				end
				strobe = !c[0];
				if (c == SEQ_Q1 || c == SEQ_Q3) begin
					quarter = 1'b1;
				end
				if (c == SEQ_Q2) begin
					quarter = 1'b1;
					half    = 1'b1;
				end
				c_inc = {1'b0, c} + 17'd1;
				if (!five) begin
					if (c == SEQ_IRQ_B) begin
						quarter = 1'b1;
						half    = 1'b1;
					end
					if ((c == SEQ_IRQ_A || c == SEQ_IRQ_B || c == SEQ_IRQ_C) && !inhibit) begin
						nxt.irq_flag = 1'b1;
					end
					if (c_inc >= SEQ_WRAP4) begin
						c_inc = {1'b0, SEQ_Q1};
					end
				end else begin
					if (c == SEQ_LAST5) begin
						quarter = 1'b1;
						half    = 1'b1;
					end
					if (c_inc >= SEQ_WRAP5) begin
						c_inc = {1'b0, SEQ_Q1};
					end
				end
				nxt.cycle_position = c_inc[COUNT_W-1:0];
			end
			ACT_WRITE: begin
				nxt.frame_register_value = item.value;
				nxt.write_pending        = 1'b1;
			end
			ACT_STATUS: begin
				seen         = cur.irq_flag;
				nxt.irq_flag = 1'b0;
			end
			default: begin
			end
		endcase

		res.quarter_frame       = quarter;
		res.half_frame          = half;
		res.half_rate_strobe    = strobe;
		res.irq_request         = nxt.irq_flag;
		res.irq_seen            = seen;
		res.frame_register_read = nxt.frame_register_value;
	end

endmodule

### design/apu_frame_sequencer.sv
// ----------------------------------------------------------------------------
// apu_frame_sequencer
// Frame sequencer: 4-step / 5-step quarter and half frame pulses, timer
// strobe and frame IRQ, one result per input transfer.
//
//   channel   | modport | payload
//   ----------+---------+-------------------------------------------------
//   cmd_ch    | sink    | action, value
//   rsp_ch    | source  | quarter/half frame, strobe, irq, irq_seen, readback
//
// Result path: input register, then the step logic feeds the result register
// and the state in the same edge.
// One transfer per cycle sustained; a stalled output holds both stages and
// backs up into cmd_ch.ready.
// Reset clears the sequencer state and both stage valids.
// ----------------------------------------------------------------------------
module apu_frame_sequencer (
	input logic  clk,
	input logic  arst_n,
	afs_in_if.sink    cmd_ch,
	afs_out_if.source rsp_ch
);
	import afs_pkg::*;

	logic       valid_s1;
	item_t      item_s1;
	logic       valid_s2;
	result_t    res_s2;
	seq_state_t state_q;
	seq_state_t state_nxt;
	result_t    res_nxt;
	logic       advance;

	assign advance      = valid_s1 && (!valid_s2 || rsp_ch.ready);
	assign cmd_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			item_s1.action <= cmd_ch.action;
			item_s1.value  <= cmd_ch.value;
		end
	end

	afs_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign rsp_ch.valid               = valid_s2;
	assign rsp_ch.quarter_frame       = res_s2.quarter_frame;
	assign rsp_ch.half_frame          = res_s2.half_frame;
	assign rsp_ch.half_rate_strobe    = res_s2.half_rate_strobe;
	assign rsp_ch.irq_request         = res_s2.irq_request;
	assign rsp_ch.irq_seen            = res_s2.irq_seen;
	assign rsp_ch.frame_register_read = res_s2.frame_register_read;

endmodule
